// ===== rtl/core/sha1bs_pkg.sv =====
// Package for the SHA-1 byte-stream hasher: payload types and constants.
package sha1bs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_position;
    logic        last_word;
  } out_item_t;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = H0;
      3'd1:    v = H1;
      3'd2:    v = H2;
      3'd3:    v = H3;
      default: v = H4;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/sha1_byte_stream_hasher_unit.sv =====
// SHA-1 byte-stream hasher: byte packing, padding, 80-round compression, digest output.
// Steps: a byte item is accepted, its memory word read, then merged and written back;
// an item with no byte and no end is simply taken in idle. A compression: load, 16
// rounds of a read and a compute, 64 rounds of four schedule reads then write back, add.
// End: pad read and write, a zero sweep of up to 15 words and one compression, plus a
// 16-word sweep and a second compression when 56 or more bytes remain, then five output
// transfers. One item at a time; ready only when idle. Sync active-low reset restores
// the chaining value, clears the byte count; the block memory has no reset.
module sha1_byte_stream_hasher_unit #(
  parameter int LENGTH_COUNTER_BITS = 61
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha1bs_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha1bs_pkg::out_item_t out_data
);

  // states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BRD    = 4'd1;  // byte read issued
  localparam logic [3:0] ST_PREP   = 4'd2;  // load working vars
  localparam logic [3:0] ST_RRD    = 4'd3;  // round: memory reads
  localparam logic [3:0] ST_RDO    = 4'd4;  // round: compute, write back
  localparam logic [3:0] ST_FIN    = 4'd5;  // add into chaining value
  localparam logic [3:0] ST_PADRD  = 4'd6;  // pad byte read
  localparam logic [3:0] ST_PADWR  = 4'd7;  // pad byte write
  localparam logic [3:0] ST_ZERO   = 4'd8;  // zero sweep
  localparam logic [3:0] ST_OUT    = 4'd9;
  localparam logic [3:0] ST_BRD2   = 4'd10; // byte write

  logic [3:0] state_r, state_nxt;

  // block/schedule memory, one port
  logic [31:0] mem [16];
  logic        mem_we;
  logic [3:0]  mem_addr;
  logic [31:0] mem_wd, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_rd_r <= mem[mem_addr];
  end

  logic [LENGTH_COUNTER_BITS-1:0] count_r, count_nxt;
  logic [31:0] cv_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  round_r, round_nxt;
  logic [1:0]  tap_r, tap_nxt;      // which of four schedule taps is read
  logic [31:0] wacc_r, wacc_nxt;    // xor accumulator
  logic [3:0]  zidx_r, zidx_nxt;
  logic        end_r, end_nxt;      // end pending after current work
  logic        final_r, final_nxt;  // current compression is the last
  logic        extra_r, extra_nxt;  // need a second padded block
  logic [2:0]  opos_r, opos_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        cv_add, cv_init, wv_load, wv_step;
  logic [31:0] t_val;
  logic [31:0] f_val, k_val, w_val;

  logic [5:0]  pos;
  assign pos = count_r[5:0];

  logic [63:0] bits;
  assign bits = {{(64 - LENGTH_COUNTER_BITS){1'b0}}, count_r} << 3;

  // round function
  always_comb begin
    if (round_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1bs_pkg::K0;
    end else if (round_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1bs_pkg::K1;
    end else if (round_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1bs_pkg::K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1bs_pkg::K3;
    end
  end

  logic [31:0] wx;
  assign wx = wacc_r ^ mem_rd_r;
  assign w_val = (round_r < 7'd16) ? mem_rd_r : {wx[30:0], wx[31]};
  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_val;

  // control
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    round_nxt = round_r;
    tap_nxt   = tap_r;
    wacc_nxt  = wacc_r;
    zidx_nxt  = zidx_r;
    end_nxt   = end_r;
    final_nxt = final_r;
    extra_nxt = extra_r;
    opos_nxt  = opos_r;
    byte_nxt  = byte_r;
    mem_we    = 1'b0;
    mem_addr  = count_r[5:2];
    mem_wd    = '0;
    cv_add    = 1'b0;
    cv_init   = 1'b0;
    wv_load   = 1'b0;
    wv_step   = 1'b0;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          end_nxt  = in_data.end_of_message;
          byte_nxt = in_data.data_byte;
          if (in_data.byte_present) begin
            state_nxt = ST_BRD;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PADRD;
          end
        end
      end
      ST_BRD: begin
        state_nxt = ST_BRD2;
      end
      ST_BRD2: begin
        mem_we = 1'b1;
        mem_wd = (pos[1:0] == 2'd0) ? {byte_r, 24'd0} :
                 (mem_rd_r | ({24'd0, byte_r} << (5'd24 - {pos[1:0], 3'd0})));
        count_nxt = count_r + 1'b1;
        final_nxt = 1'b0;
        if (pos == 6'd63) begin
          state_nxt = ST_PREP;
        end else if (end_r) begin
          state_nxt = ST_PADRD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PADRD: begin
        state_nxt = ST_PADWR;
      end
      ST_PADWR: begin
        mem_we = 1'b1;
        mem_wd = (pos[1:0] == 2'd0) ? {sha1bs_pkg::PAD_BYTE, 24'd0} :
                 (mem_rd_r | ({24'd0, sha1bs_pkg::PAD_BYTE} << (5'd24 - {pos[1:0], 3'd0})));
        extra_nxt = (pos >= 6'd56);
        zidx_nxt  = pos[5:2] + 4'd1;
        state_nxt = (pos[5:2] == 4'd15) ? ST_PREP : ST_ZERO;
        final_nxt = (pos < 6'd56);
        if (pos[5:2] == 4'd15 && pos < 6'd56) state_nxt = ST_ZERO;
      end
      ST_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = zidx_r;
        if (final_r && zidx_r == 4'd14) mem_wd = bits[63:32];
        else if (final_r && zidx_r == 4'd15) mem_wd = bits[31:0];
        else mem_wd = '0;
        zidx_nxt = zidx_r + 4'd1;
        if (zidx_r == 4'd15) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        wv_load   = 1'b1;
        round_nxt = '0;
        tap_nxt   = '0;
        wacc_nxt  = '0;
        state_nxt = ST_RRD;
      end
      ST_RRD: begin
        // issue read of a schedule tap: slot+13, +8, +2, then slot
        case (tap_r)
          2'd0:    mem_addr = round_r[3:0] + 4'd13;
          2'd1:    mem_addr = round_r[3:0] + 4'd8;
          2'd2:    mem_addr = round_r[3:0] + 4'd2;
          default: mem_addr = round_r[3:0];
        endcase
        if (round_r < 7'd16) mem_addr = round_r[3:0];
        state_nxt = ST_RDO;
      end
      ST_RDO: begin
        mem_addr = round_r[3:0];
        if (round_r >= 7'd16 && tap_r != 2'd3) begin
          wacc_nxt  = wacc_r ^ mem_rd_r;
          tap_nxt   = tap_r + 2'd1;
          state_nxt = ST_RRD;
        end else begin
          wv_step  = 1'b1;
          mem_we   = (round_r >= 7'd16);
          mem_wd   = w_val;
          tap_nxt  = '0;
          wacc_nxt = '0;
          round_nxt = round_r + 7'd1;
          state_nxt = (round_r == 7'd79) ? ST_FIN : ST_RRD;
        end
      end
      ST_FIN: begin
        cv_add    = 1'b1;
        round_nxt = '0;
        if (!end_r) begin
          state_nxt = ST_IDLE;
        end else if (final_r) begin
          opos_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (count_r[5:0] == 6'd0 && !extra_r) begin
          // block just filled by the end byte: pad into a fresh block
          state_nxt = ST_PADRD;
        end else begin
          // second padded block: all zero then length
          final_nxt = 1'b1;
          extra_nxt = 1'b0;
          zidx_nxt  = '0;
          state_nxt = ST_ZERO;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          opos_nxt = opos_r + 3'd1;
          if (opos_r == 3'd4) begin
            cv_init   = 1'b1;
            count_nxt = '0;
            end_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_data.digest_word   = cv_r[opos_r];
  assign out_data.word_position = opos_r;
  assign out_data.last_word     = (opos_r == 3'd4);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      round_r <= '0;
      tap_r   <= '0;
      zidx_r  <= '0;
      end_r   <= 1'b0;
      final_r <= 1'b0;
      extra_r <= 1'b0;
      opos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      round_r <= round_nxt;
      tap_r   <= tap_nxt;
      zidx_r  <= zidx_nxt;
      end_r   <= end_nxt;
      final_r <= final_nxt;
      extra_r <= extra_nxt;
      opos_r  <= opos_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    wacc_r <= wacc_nxt;
    byte_r <= byte_nxt;
    if (wv_load) begin
      a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2]; d_r <= cv_r[3]; e_r <= cv_r[4];
    end else if (wv_step) begin
      e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= t_val;
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    for (int i = 0; i < 5; i++) begin
      if (!rst_n || cv_init) begin
        cv_r[i] <= sha1bs_pkg::init_hash(3'(i));
      end else if (cv_add) begin
        case (i)
          0:       cv_r[i] <= cv_r[i] + a_r;
          1:       cv_r[i] <= cv_r[i] + b_r;
          2:       cv_r[i] <= cv_r[i] + c_r;
          3:       cv_r[i] <= cv_r[i] + d_r;
          default: cv_r[i] <= cv_r[i] + e_r;
        endcase
      end
    end
  end

  // checks
  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.word_position <= 3'd4)) else $error("bad word position");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (round_r <= 7'd80)) else $error("round index overflow");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the SHA-1 byte-stream hasher unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Digest model: tracks chaining value, block and byte count
  class digest_board;
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [60:0] nbytes;
    sha1bs_pkg::out_item_t pending [$];
    int          errors;
    int          digests;

    function new();
      errors = 0;
      digests = 0;
      clear();
    endfunction

    function void clear();
      chain[0] = 32'h67452301; chain[1] = 32'hefcdab89; chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476; chain[4] = 32'hc3d2e1f0;
      nbytes = '0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int r;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (r = 0; r < 80; r++) begin
        if (r >= 16) begin
          x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
          w[r % 16] = {x[30:0], x[31]};
        end
        if (r < 20) begin
          f = (b & c) | (~b & d); k = 32'h5a827999;
        end else if (r < 40) begin
          f = b ^ c ^ d; k = 32'h6ed9eba1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
        end else begin
          f = b ^ c ^ d; k = 32'hca62c1d6;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
        e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void put(int pos, logic [7:0] v);
      int lane;
      lane = pos % 4;
      if (lane == 0) blk[pos / 4] = '0;
      blk[pos / 4][31 - 8 * lane -: 8] = v;
    endfunction

    // Note an accepted input transfer
    function void note_input(sha1bs_pkg::in_item_t it);
      int pos;
      logic [63:0] bits;
      sha1bs_pkg::out_item_t o;
      if (it.byte_present) begin
        pos = nbytes[5:0];
        put(pos, it.data_byte);
        nbytes = nbytes + 1;
        if (pos == 63) compress();
      end
      if (!it.end_of_message) return;
      pos = nbytes[5:0];
      put(pos, sha1bs_pkg::PAD_BYTE);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {nbytes, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 5; i++) begin
        o.digest_word = chain[i];
        o.word_position = 3'(i);
        o.last_word = (i == 4);
        pending.push_back(o);
      end
      digests++;
      clear();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Check one result transfer against the oldest expected word
    task check_word(sha1bs_pkg::out_item_t got);
      sha1bs_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected digest word %h", got.digest_word));
        return;
      end
      exp = pending.pop_front();
      if (got.digest_word !== exp.digest_word)
        report($sformatf("word %0d: got %h exp %h", exp.word_position,
                         got.digest_word, exp.digest_word));
      if (got.word_position !== exp.word_position)
        report($sformatf("position: got %0d exp %0d", got.word_position,
                         exp.word_position));
      if (got.last_word !== exp.last_word)
        report($sformatf("last flag: got %b exp %b", got.last_word, exp.last_word));
    endtask
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  sha1bs_pkg::in_item_t  in_data;
  sha1bs_pkg::out_item_t out_data;
  digest_board board;
  int items_sent, idle_ms, watchdog;
  bit calm;

  localparam int TIMEOUT = 20000;

  sha1_byte_stream_hasher_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Monitor, scoreboard hookup and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_word(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog > TIMEOUT) begin
        $display("watchdog expired with %0d words pending", board.pending.size());
        $display("sha1_byte_stream_hasher_unit test failed");
        $finish;
      end
    end
  end

  // Result-side stalls in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      idle_ms <= 0;
    end else if (idle_ms > 0) begin
      idle_ms <= idle_ms - 1;
      out_ready <= calm;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      idle_ms <= $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Send one item and wait for its transfer; valid stays up into the next item
  task automatic send(logic [7:0] b, bit pres, bit eom);
    sha1bs_pkg::in_item_t it;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    it.data_byte = b; it.byte_present = pres; it.end_of_message = eom;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(0, 1)) begin
        send(8'($urandom), 1'b1, 1'b1);
        return;
      end
      send(8'($urandom), 1'b1, 1'b0);
    end
    send(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop sending and wait until every expected word has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 0;
    items_sent = 0;
    watchdog = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, "abc", byte with end, extreme bytes, a no-op item
    send(8'h00, 1'b0, 1'b1);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'h63, 1'b1, 1'b1);
    send(8'hff, 1'b0, 1'b0);
    send(8'hff, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'h55, 1'b1, 1'b0);
    send(8'haa, 1'b1, 1'b1);
    drain();

    // Padding spills into an extra block (56 bytes)
    send_message(56);
    drain();

    // Closing stretch without idling: a message that fills a whole block
    calm = 1;
    send_message(64);
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d items and %0d digests: empty, short, 56- and 64-byte messages,",
             items_sent, board.digests);
    $display("no-op items and bytes with end, random stalls on both sides, then none");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("sha1_byte_stream_hasher_unit test passed");
    else
      $display("sha1_byte_stream_hasher_unit test failed");
    $finish;
  end
endmodule

// ===== sha1_byte_stream_hasher_unit.f =====
rtl/core/sha1bs_pkg.sv
rtl/core/sha1_byte_stream_hasher_unit.sv
test/testbench.sv
